// ----- rtl/core/lzwd_pkg.sv -----
// Shared types and constants of the LZ window RTF decompressor.
package lzwd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int FLAG_CNT_W  = 4;
    localparam int COPY_CNT_W  = 5;

    localparam logic [FLAG_CNT_W-1:0] FLAG_BITS_PER_BYTE = FLAG_CNT_W'(8);

    // Codes of the input request kind carried on s_tuser.
    localparam logic REQ_PRELOAD = 1'b0;
    localparam logic REQ_STREAM  = 1'b1;

    // Token phase codes.
    localparam logic PHASE_TOKEN   = 1'b0;
    localparam logic PHASE_REF_LOW = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR   = 4'b0001,
        ST_IDLE    = 4'b0010,
        ST_COPY_RD = 4'b0100,
        ST_COPY_WR = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic preload;
        logic flag_load;
        logic first_load;
        logic ref_start;
        logic literal;
        logic copy_rd;
        logic copy_wr;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic ref_pending;
        logic flags_empty;
        logic flag_ref;
        logic copy_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/lz_window_rtf_decompressor.sv -----
// Top level of the LZ window RTF decompressor.
//
// This block expands an LZFu compressed RTF body arriving one byte per
// transfer on the s_ channel and delivers the decompressed bytes one per
// transfer on the m_ channel. An input transfer with s_tuser low preloads one
// byte of the initial dictionary text; with s_tuser high it is one byte of the
// compressed body (flag byte, literal, or one of the two bytes of a
// back-reference into the 4096-byte circular dictionary). The user must write
// the output length through the cfg_ channel only while the block is idle; the
// block itself does not enforce this. Bytes beyond that length are still
// decoded into the dictionary but are not delivered. m_tlast marks the last
// byte produced for one input transfer and m_tuser marks the byte that
// completes the output length. After reset the dictionary is swept to zero
// one entry per cycle, so s_tready stays low until it ends; configuration
// transfers are taken at any time. A preload, flag byte, first reference byte
// or literal is handled in the idle state. The second byte of a reference
// starts a copy that runs byte by byte: a dictionary read state, then a write
// and output state that waits while the output register is full.
// An output register sits between the decoder and the m_ side. While a result
// waits in it the input is held off; the next input transfer can be taken in
// the same cycle that the waiting result is taken.
module lz_window_rtf_decompressor (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lzwd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] req_type
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lzwd_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tuser,   // [0] stream_end
    // Output length register write.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lzwd_pkg::LEN_W-1:0]   cfg_data
);
    import lzwd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The register can always be written.
    assign cfg_ready = 1'b1;

    lzwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lzwd_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/core/lzwd_ctrl.sv -----
// Controller state machine of the LZ window RTF decompressor.
module lzwd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  lzwd_pkg::dp_stat_t stat,
    output lzwd_pkg::dp_cmd_t  cmd
);
    import lzwd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_PRELOAD) begin
                        cmd.preload = 1'b1;
                    end else if (stat.ref_pending) begin
                        cmd.ref_start = 1'b1;
                        state_next    = ST_COPY_RD;
                    end else if (stat.flags_empty) begin
                        cmd.flag_load = 1'b1;
                    end else if (stat.flag_ref) begin
                        cmd.first_load = 1'b1;
                    end else begin
                        cmd.literal = 1'b1;
                    end
                end
            end
            ST_COPY_RD: begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (stat.out_free) begin
                    cmd.copy_wr = 1'b1;
                    state_next  = stat.copy_last ? ST_IDLE : ST_COPY_RD;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/lzwd_dpath.sv -----
// Datapath of the LZ window RTF decompressor: dictionary, token state and output register.
module lzwd_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lzwd_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         cfg_valid,
    input  logic [lzwd_pkg::LEN_W-1:0]   cfg_data,
    input  lzwd_pkg::dp_cmd_t            cmd,
    output lzwd_pkg::dp_stat_t           stat,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lzwd_pkg::BYTE_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);
    import lzwd_pkg::*;

    logic [BYTE_W-1:0]     dict_mem [WINDOW_SIZE];
    logic [BYTE_W-1:0]     rd_data_reg;

    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     wp_reg;
    logic [BYTE_W-1:0]     flag_bits_reg;
    logic [FLAG_CNT_W-1:0] flag_left_reg;
    logic                  phase_reg;
    logic [BYTE_W-1:0]     first_reg;
    logic [LEN_W-1:0]      produced_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [ADDR_W-1:0]     copy_addr_reg;
    logic [COPY_CNT_W-1:0] copy_left_reg;

    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     m_data_reg;
    logic                  m_last_reg;
    logic                  m_end_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [BYTE_W-1:0]     mem_wdata;
    logic                  emit;
    logic                  emit_en;
    logic                  consume;
    logic [LEN_W-1:0]      produced_inc;
    logic                  reach_end;

    // Dictionary write port: clearing sweep, preload, literal or copied byte.
    always_comb begin
        mem_we    = cmd.clr_wr || cmd.preload || cmd.literal || cmd.copy_wr;
        mem_waddr = cmd.clr_wr ? clr_addr_reg : wp_reg;
        if (cmd.clr_wr) begin
            mem_wdata = '0;
        end else if (cmd.copy_wr) begin
            mem_wdata = rd_data_reg;
        end else begin
            mem_wdata = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dict_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_rd) begin
            rd_data_reg <= dict_mem[copy_addr_reg];
        end
    end

    assign emit         = cmd.literal || cmd.copy_wr;
    assign emit_en      = produced_reg < out_len_reg;
    assign produced_inc = produced_reg + LEN_W'(1);
    assign reach_end    = produced_inc == out_len_reg;
    assign consume      = cmd.literal || cmd.ref_start;

    assign stat.clr_last    = clr_addr_reg == ADDR_W'(WINDOW_SIZE - 1);
    assign stat.ref_pending = phase_reg == PHASE_REF_LOW;
    assign stat.flags_empty = flag_left_reg == '0;
    assign stat.flag_ref    = flag_bits_reg[0];
    assign stat.copy_last   = copy_left_reg == '0;
    assign stat.out_free    = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            wp_reg        <= '0;
            flag_bits_reg <= '0;
            flag_left_reg <= '0;
            phase_reg     <= PHASE_TOKEN;
            first_reg     <= '0;
            produced_reg  <= '0;
            out_len_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                out_len_reg <= cfg_data;
            end
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.preload || cmd.literal || cmd.copy_wr) begin
                wp_reg <= wp_reg + ADDR_W'(1);
            end
            if (cmd.flag_load) begin
                flag_bits_reg <= s_tdata;
                flag_left_reg <= FLAG_BITS_PER_BYTE;
                phase_reg     <= PHASE_TOKEN;
            end
            if (cmd.first_load) begin
                first_reg <= s_tdata;
                phase_reg <= PHASE_REF_LOW;
            end
            if (consume) begin
                flag_bits_reg <= flag_bits_reg >> 1;
                if (flag_left_reg != '0) begin
                    flag_left_reg <= flag_left_reg - FLAG_CNT_W'(1);
                end
                phase_reg <= PHASE_TOKEN;
            end
            if (emit && emit_en) begin
                m_valid_reg  <= 1'b1;
                produced_reg <= produced_inc;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Copy address and count, plus the output payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.ref_start) begin
            copy_addr_reg <= {first_reg, s_tdata[BYTE_W-1:4]};
            copy_left_reg <= {1'b0, s_tdata[3:0]} + COPY_CNT_W'(1);
        end else if (cmd.copy_wr) begin
            copy_addr_reg <= copy_addr_reg + ADDR_W'(1);
            copy_left_reg <= copy_left_reg - COPY_CNT_W'(1);
        end
        if (emit && emit_en) begin
            m_data_reg <= mem_wdata;
            m_last_reg <= cmd.literal || (copy_left_reg == '0) || reach_end;
            m_end_reg  <= reach_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_end_reg;

endmodule

// ----- rtl/core/lzwd_checker.sv -----
// Port-level assertions of the LZ window RTF decompressor and their bind.
module lzwd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lzwd_pkg::BYTE_W-1:0]  m_tdata,
    input logic                         m_tlast,
    input logic                         m_tuser
);
    import lzwd_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The byte that ends the stream is always the last one of its run.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream end without last of run");

    // A preload transfer never produces a result.
    a_preload_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_PRELOAD) |=> !m_tvalid)
        else $error("result after dictionary preload");

    // Coming out of reset the dictionary sweep holds the input off.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("handshake active right after reset");

endmodule

bind lz_window_rtf_decompressor lzwd_checker u_lzwd_checker (.*);

// ----- tb/tb_lz_window_rtf_decompressor.sv -----
// Self-checking testbench for the LZ window RTF decompressor.
`timescale 1ns / 1ps

module tb_lz_window_rtf_decompressor;
    import lzwd_pkg::*;

    // Run limit in ns: the dictionary sweep plus several times the slowest
    // legal run (every reference at full length, long output stalls).
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;
    // Cycles that the block may still spend on an input transfer that gives
    // no result, such as a full-length copy with its output dropped.
    localparam int QUIET_CYCLES = 64;
    localparam int SCRIPT_ROWS = 29;
    localparam int REPORT_CAP = 40;

    // One expected result transfer on the m_ channel.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              stream_end;
    } out_rec_t;

    // Rows of the directed script. A non-negative count types in the results
    // that the row must give: that many copies of one byte value.
    typedef enum logic [1:0] {
        ROW_PRELOAD,
        ROW_STREAM,
        ROW_SET_LEN,
        ROW_ADD_LEN
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [LEN_W-1:0] value;
        int               n_exp;
        logic [7:0]       exp_byte;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              s_tuser = REQ_PRELOAD;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;

    lz_window_rtf_decompressor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_byte
        .s_tuser   (s_tuser),    // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_byte
        .m_tlast   (m_tlast),    // last_of_run
        .m_tuser   (m_tuser),    // [0] stream_end
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder state kept by the testbench. It mirrors what the block holds
    // after reset: an all-zero dictionary, no flag byte, nothing produced.
    // ------------------------------------------------------------------
    logic [7:0]       dict_mem [WINDOW_SIZE] = '{default: 8'h00};
    logic [11:0]      wr_pos = '0;
    logic [7:0]       flag_reg = '0;
    logic [3:0]       flags_left = '0;
    logic             ref_phase = PHASE_TOKEN;
    logic [7:0]       ref_hi = '0;
    logic [LEN_W-1:0] produced = '0;
    logic [LEN_W-1:0] out_len = '0;

    out_rec_t expected_out [$];   // results still owed by the block, oldest first
    out_rec_t run_out [$];        // results of the most recent input transfer
    int errors = 0;
    int items_sent = 0;
    int burst_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= REPORT_CAP)
            $display("mismatch at %0t: %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic void store_byte(input logic [7:0] b);
        dict_mem[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
    endfunction

    // Every decoded byte enters the dictionary; only the ones within the
    // configured output length become result transfers.
    function automatic void produce_byte(input logic [7:0] b);
        out_rec_t rec;
        store_byte(b);
        if (produced < out_len) begin
            produced = produced + 1'b1;
            rec = '{b, 1'b0, produced == out_len};
            run_out.push_back(rec);
        end
    endfunction

    function automatic void shift_flag();
        flag_reg = flag_reg >> 1;
        if (flags_left != 0)
            flags_left = flags_left - 1'b1;
    endfunction

    // Works out the results of one accepted input transfer and queues them.
    function automatic void decode_transfer(input logic kind, input logic [7:0] b);
        logic [11:0] offset;
        int span;
        run_out.delete();
        if (kind == REQ_PRELOAD) begin
            // A preload never touches the token parser.
            store_byte(b);
        end else if (ref_phase == PHASE_REF_LOW) begin
            // Second reference byte: absolute offset and length. The copy
            // runs byte by byte, so an overlap repeats the bytes just written,
            // and an offset equal to the write position reads the old byte.
            offset = {ref_hi, b[7:4]};
            span = int'(b[3:0]) + 2;
            for (int i = 0; i < span; i++)
                produce_byte(dict_mem[offset + 12'(i)]);
            ref_phase = PHASE_TOKEN;
            shift_flag();
        end else if (flags_left == 0) begin
            flag_reg = b;
            flags_left = FLAG_BITS_PER_BYTE;
        end else if (flag_reg[0]) begin
            ref_hi = b;
            ref_phase = PHASE_REF_LOW;
        end else begin
            produce_byte(b);
            shift_flag();
        end
        if (run_out.size() > 0)
            run_out[run_out.size() - 1].last_of_run = 1'b1;
        foreach (run_out[k])
            expected_out.push_back(run_out[k]);
    endfunction

    // ------------------------------------------------------------------
    // Sender. It works in bursts; between most bursts s_tvalid drops for a random
    // number of cycles. A transfer is predicted as soon as it is accepted.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic kind, input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
        decode_transfer(kind, b);
    endtask

    // Holds the sender off until every expected result has been delivered.
    // It always waits on the clock before it checks, so s_tvalid is never lowered
    // and raised again within one time step.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_out.size() != 0);
    endtask

    // The output length is only changed while the block is idle: all results
    // delivered, and time for a copy whose output was dropped to finish.
    task automatic write_output_length(input logic [LEN_W-1:0] len_val);
        wait_results_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= len_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        out_len = len_val;
    endtask

    // One well-formed group: a flag byte and its eight tokens with random
    // content. References lean toward the write position to get overlapping
    // copies and the full-window read back. Now and then a preload is slipped
    // in between tokens, or the group is cut short so that the parser goes
    // out of step with the sender's idea of the stream.
    task automatic send_group();
        logic [7:0]  flags;
        logic [11:0] off;
        int stop;
        if ($urandom_range(0, 24) == 0)
            wait_results_drained();
        flags = 8'($urandom_range(0, 255));
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
        send_byte(REQ_STREAM, flags);
        for (int i = 0; i < stop; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_byte(REQ_PRELOAD, 8'($urandom_range(0, 255)));
            if (flags[i]) begin
                case ($urandom_range(0, 3))
                    0: off = wr_pos - 12'($urandom_range(1, 4));
                    1: off = wr_pos;
                    default: off = 12'($urandom_range(0, WINDOW_SIZE - 1));
                endcase
                send_byte(REQ_STREAM, off[11:4]);
                send_byte(REQ_STREAM, {off[3:0], 4'($urandom_range(0, 15))});
            end else begin
                send_byte(REQ_STREAM, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver. Its readiness follows a mode that is redrawn at random:
    // always ready, coin flip, one cycle in four, or mostly stalled.
    // ------------------------------------------------------------------
    int rx_cycle = 0;
    int rx_mode = 0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Each result transfer is compared, field by field, with the oldest one
    // still owed.
    always @(posedge aclk) begin : check_results
        out_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                report_mismatch("result with none expected", m_tdata, 0);
            end else begin
                want = expected_out.pop_front();
                if (m_tdata !== want.out_byte)
                    report_mismatch("out_byte", m_tdata, want.out_byte);
                if (m_tlast !== want.last_of_run)
                    report_mismatch("last_of_run", m_tlast, want.last_of_run);
                if (m_tuser !== want.stream_end)
                    report_mismatch("stream_end", m_tuser, want.stream_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed script. After reset the dictionary is all zeros and the write
    // position is 0; the typed counts and bytes follow from that.
    // ------------------------------------------------------------------
    row_t script [SCRIPT_ROWS] = '{
        // Zero output length: a full 17-byte copy from offset 0 gives nothing.
        '{ROW_SET_LEN, 24'h000000, -1, 8'h00},
        '{ROW_STREAM,  24'h000001,  0, 8'h00},   // flag byte, first token a reference
        '{ROW_STREAM,  24'h000000,  0, 8'h00},
        '{ROW_STREAM,  24'h00000F,  0, 8'h00},
        // Largest output length from here on.
        '{ROW_SET_LEN, 24'hFFFFFF, -1, 8'h00},
        // Preloads in the middle of a flag group, at positions 17 and 18.
        '{ROW_PRELOAD, 24'h000041,  0, 8'h00},
        '{ROW_PRELOAD, 24'h0000FF,  0, 8'h00},
        // The remaining seven tokens of the group are literals.
        '{ROW_STREAM,  24'h000000,  1, 8'h00},
        '{ROW_STREAM,  24'h0000FF,  1, 8'hFF},
        '{ROW_STREAM,  24'h000080,  1, 8'h80},
        '{ROW_STREAM,  24'h00007F,  1, 8'h7F},
        '{ROW_STREAM,  24'h000055,  1, 8'h55},
        '{ROW_STREAM,  24'h0000AA,  1, 8'hAA},
        '{ROW_STREAM,  24'h000001,  1, 8'h01},
        // Flag byte with every token a reference.
        '{ROW_STREAM,  24'h0000FF,  0, 8'h00},
        // Offset 4095, length 17: wraps the window and reads only zeros.
        '{ROW_STREAM,  24'h0000FF,  0, 8'h00},
        '{ROW_STREAM,  24'h0000FF, 17, 8'h00},
        // Offset 17, length 2: reads back the preloaded bytes.
        '{ROW_STREAM,  24'h000001,  0, 8'h00},
        '{ROW_STREAM,  24'h000010, -1, 8'h00},
        // Offset 45 equals the write position: the old bytes come back.
        '{ROW_STREAM,  24'h000002,  0, 8'h00},
        '{ROW_STREAM,  24'h0000D0,  2, 8'h00},
        // Offset 43, length 5: the copy overlaps what it has just written.
        '{ROW_STREAM,  24'h000002,  0, 8'h00},
        '{ROW_STREAM,  24'h0000B3, -1, 8'h00},
        // Three more bytes allowed: a 7-byte copy delivers 3 and ends the stream.
        '{ROW_ADD_LEN, 24'h000003, -1, 8'h00},
        '{ROW_STREAM,  24'h000000,  0, 8'h00},
        '{ROW_STREAM,  24'h000005,  3, 8'h00},
        // Length equal to the bytes already produced: nothing more comes out.
        '{ROW_ADD_LEN, 24'h000000, -1, 8'h00},
        '{ROW_STREAM,  24'h000012,  0, 8'h00},
        '{ROW_STREAM,  24'h000034,  0, 8'h00}
    };

    initial begin : stimulus
        logic [LEN_W-1:0] len_val;
        int quota;
        int stop_at;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            case (script[r].kind)
                ROW_SET_LEN: write_output_length(script[r].value);
                ROW_ADD_LEN: write_output_length(produced + script[r].value);
                default: begin
                    send_byte(script[r].kind == ROW_PRELOAD ? REQ_PRELOAD : REQ_STREAM,
                              script[r].value[7:0]);
                    if (script[r].n_exp >= 0) begin
                        if (run_out.size() != script[r].n_exp)
                            report_mismatch("result count of script row",
                                            run_out.size(), script[r].n_exp);
                        foreach (run_out[k])
                            if (run_out[k].out_byte != script[r].exp_byte)
                                report_mismatch("result byte of script row",
                                                run_out[k].out_byte, script[r].exp_byte);
                    end
                end
            endcase
        end

        // Random part, in phases of different output lengths: unlimited, a
        // limit reached partway, zero, a limit only a few bytes ahead, and
        // unlimited again.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin len_val = '1; quota = 70; end
                1: begin len_val = produced + LEN_W'($urandom_range(40, 160)); quota = 50; end
                2: begin len_val = '0; quota = 30; end
                3: begin len_val = produced + LEN_W'($urandom_range(1, 8)); quota = 30; end
                default: begin len_val = '1; quota = 65; end
            endcase
            write_output_length(len_val);
            stop_at = items_sent + quota;
            while (items_sent < stop_at)
                send_group();
        end

        // Let every owed result arrive, then watch for stray extra transfers.
        wait_results_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (expected_out.size() != 0)
            report_mismatch("results never delivered", expected_out.size(), 0);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop for a block that hangs.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lzwd_pkg.sv
rtl/core/lzwd_ctrl.sv
rtl/core/lzwd_dpath.sv
rtl/core/lz_window_rtf_decompressor.sv
rtl/core/lzwd_checker.sv
tb/tb_lz_window_rtf_decompressor.sv
